>>> sv/spotl_pkg.sv
package spotl_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int LANES = 3;
	localparam int SQRT_STEPS = 32;
	localparam int DIR_Q_BITS = 15;
	localparam int FALL_Q_BITS = 14;
	localparam int CHAN_Q_BITS = 32;

	localparam logic [15:0] INTENSITY_RST = 16'd256;
	localparam logic [15:0] COS_CUTOFF_RST = 16'd15396;
	localparam logic [15:0] COS_BEAM_RST = 16'd15826;
	localparam logic [14:0] FALL_ONE = 15'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIGHT_POS_X = 3'd0,
		CFG_LIGHT_POS_Y = 3'd1,
		CFG_LIGHT_POS_Z = 3'd2,
		CFG_INTENSITY_R = 3'd3,
		CFG_INTENSITY_G = 3'd4,
		CFG_INTENSITY_B = 3'd5,
		CFG_COS_CUTOFF = 3'd6,
		CFG_COS_BEAM = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FALL_OFF = 2'd0,
		FALL_FULL = 2'd1,
		FALL_DIV = 2'd2
	} fall_mode_t;

	// per-item flags carried down the pipe
	typedef struct packed {
		logic [LANES-1:0] neg;
		logic zero;
		logic shf;
		logic [63:0] s;
	} side_t;

	typedef struct packed {
		logic [63:0] rad;
		logic [31:0] root;
		logic [32:0] rem;
		logic [LANES-1:0][30:0] n;
		side_t sd;
	} sq_t;

	typedef struct packed {
		logic [LANES-1:0][46:0] r;
		logic [LANES-1:0][DIR_Q_BITS-1:0] q;
		logic [31:0] len;
		side_t sd;
	} dv_t;

	typedef struct packed {
		logic [LANES-1:0][15:0] d;
		side_t sd;
	} dir_t;

	typedef struct packed {
		logic [29:0] rem;
		logic [15:0] den;
		logic [FALL_Q_BITS-1:0] q;
		fall_mode_t mode;
		dir_t dr;
	} fl_t;

	typedef struct packed {
		logic [LANES-1:0][30:0] p;
		dir_t dr;
	} pr_t;

	typedef struct packed {
		logic [LANES-1:0][56:0] rem;
		logic [LANES-1:0][CHAN_Q_BITS-1:0] q;
		logic [LANES-1:0] sat;
		dir_t dr;
	} ch_t;

	function automatic logic [4:0] lzc31(input logic [30:0] v);
		logic [4:0] c;
		logic hit;
		c = '0;
		hit = 1'b0;
		for (int i = 30; i >= 0; i--) begin
			if (!hit) begin
				if (v[i]) begin
					hit = 1'b1;
				end else begin
					c = c + 5'd1;
				end
			end
		end
		return c;
	endfunction

endpackage

>>> sv/spot_light_attenuation.sv
// Spot light evaluation, one shaded point per clock unless the output stalls.
// Each transfer in gives one transfer out. The depth comes from the 32-stage
// square root and the 32-stage per-channel divide, each one bit per stage, plus
// the direction and falloff divides. A stalled output freezes the whole pipe,
// so in_stall follows out_valid && out_stall. Configuration is written through
// cfg_wr_en/cfg_index/cfg_data and must only change while the pipe is empty.
module spot_light_attenuation (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [spotl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spotl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z,
	output logic [31:0] value_r,
	output logic [31:0] value_g,
	output logic [31:0] value_b,
	output logic zero_distance
);
	import spotl_pkg::*;

	logic adv;

	logic [31:0] light_pos_x_q, light_pos_y_q, light_pos_z_q;
	logic [15:0] intensity_r_q, intensity_g_q, intensity_b_q;
	logic [15:0] cos_cutoff_q, cos_beam_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_pos_x_q <= '0;
			light_pos_y_q <= '0;
			light_pos_z_q <= '0;
			intensity_r_q <= INTENSITY_RST;
			intensity_g_q <= INTENSITY_RST;
			intensity_b_q <= INTENSITY_RST;
			cos_cutoff_q <= COS_CUTOFF_RST;
			cos_beam_q <= COS_BEAM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LIGHT_POS_X: light_pos_x_q <= cfg_data;
				CFG_LIGHT_POS_Y: light_pos_y_q <= cfg_data;
				CFG_LIGHT_POS_Z: light_pos_z_q <= cfg_data;
				CFG_INTENSITY_R: intensity_r_q <= cfg_data[15:0];
				CFG_INTENSITY_G: intensity_g_q <= cfg_data[15:0];
				CFG_INTENSITY_B: intensity_b_q <= cfg_data[15:0];
				CFG_COS_CUTOFF: cos_cutoff_q <= cfg_data[15:0];
				CFG_COS_BEAM: cos_beam_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: offset from light and magnitudes
	logic [LANES-1:0][32:0] dif;
	logic [LANES-1:0][31:0] a_d;
	logic [LANES-1:0][31:0] a_s1;
	logic [LANES-1:0] neg_s1;
	logic v_s1;

	assign dif[0] = {point_x[31], point_x} - {light_pos_x_q[31], light_pos_x_q};
	assign dif[1] = {point_y[31], point_y} - {light_pos_y_q[31], light_pos_y_q};
	assign dif[2] = {point_z[31], point_z} - {light_pos_z_q[31], light_pos_z_q};

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			a_d[l] = dif[l][32] ? 32'(-dif[l]) : dif[l][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= a_d;
			for (int l = 0; l < LANES; l++) begin
				neg_s1[l] <= dif[l][32];
			end
		end
	end

	// stage 2: largest magnitude, shift choice
	logic [31:0] m_d;
	logic [LANES-1:0][31:0] a_s2;
	logic [LANES-1:0] neg_s2;
	logic shf_s2, zero_s2;
	logic [4:0] k_s2;
	logic v_s2;

	always_comb begin
		m_d = a_s1[0];
		if (a_s1[1] > m_d) begin
			m_d = a_s1[1];
		end
		if (a_s1[2] > m_d) begin
			m_d = a_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= a_s1;
			neg_s2 <= neg_s1;
			shf_s2 <= m_d[31];
			zero_s2 <= (m_d == '0);
			k_s2 <= lzc31(m_d[30:0]);
		end
	end

	// stage 3: normalize
	logic [LANES-1:0][30:0] n_s3;
	logic [LANES-1:0] neg_s3;
	logic shf_s3, zero_s3;
	logic [4:0] k_s3;
	logic v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				n_s3[l] <= shf_s2 ? a_s2[l][31:1] : 31'(a_s2[l][30:0] << k_s2);
			end
			neg_s3 <= neg_s2;
			shf_s3 <= shf_s2;
			zero_s3 <= zero_s2;
			k_s3 <= k_s2;
		end
	end

	// stage 4: squares
	logic [LANES-1:0][61:0] sqr_s4;
	logic [LANES-1:0][30:0] n_s4;
	logic [LANES-1:0] neg_s4;
	logic shf_s4, zero_s4;
	logic [4:0] k_s4;
	logic v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				sqr_s4[l] <= 62'(n_s3[l]) * 62'(n_s3[l]);
			end
			n_s4 <= n_s3;
			neg_s4 <= neg_s3;
			shf_s4 <= shf_s3;
			zero_s4 <= zero_s3;
			k_s4 <= k_s3;
		end
	end

	// stage 5: sum of squares, unnormalized divisor
	logic [63:0] sum_d;
	sq_t sq_s [0:SQRT_STEPS];
	logic sq_v_s [0:SQRT_STEPS];

	assign sum_d = 64'(sqr_s4[0]) + 64'(sqr_s4[1]) + 64'(sqr_s4[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].rad <= sum_d;
			sq_s[0].root <= '0;
			sq_s[0].rem <= '0;
			sq_s[0].n <= n_s4;
			sq_s[0].sd.neg <= neg_s4;
			sq_s[0].sd.zero <= zero_s4;
			sq_s[0].sd.shf <= shf_s4;
			sq_s[0].sd.s <= shf_s4 ? sum_d : (sum_d >> {k_s4, 1'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			sq_v_s[0] <= v_s4;
		end
	end

	// square root, one result bit per stage
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		logic [34:0] cur, trial;
		assign cur = {sq_s[i].rem, sq_s[i].rad[63:62]};
		assign trial = {1'b0, sq_s[i].root, 2'b01};

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[i+1].n <= sq_s[i].n;
				sq_s[i+1].sd <= sq_s[i].sd;
				sq_s[i+1].rad <= {sq_s[i].rad[61:0], 2'b00};
				if (cur >= trial) begin
					sq_s[i+1].rem <= 33'(cur - trial);
					sq_s[i+1].root <= {sq_s[i].root[30:0], 1'b1};
				end else begin
					sq_s[i+1].rem <= cur[32:0];
					sq_s[i+1].root <= {sq_s[i].root[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[i+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[i+1] <= sq_v_s[i];
			end
		end
	end

	// direction divide: round(n * 2^14 / len)
	dv_t dv_s [0:DIR_Q_BITS];
	logic dv_v_s [0:DIR_Q_BITS];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				dv_s[0].r[l] <= 47'({sq_s[SQRT_STEPS].n[l], 14'b0})
					+ 47'(sq_s[SQRT_STEPS].root[31:1]);
			end
			dv_s[0].q <= '0;
			dv_s[0].len <= sq_s[SQRT_STEPS].root;
			dv_s[0].sd <= sq_s[SQRT_STEPS].sd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= sq_v_s[SQRT_STEPS];
		end
	end

	for (genvar t = 0; t < DIR_Q_BITS; t++) begin : g_dir
		localparam int J = DIR_Q_BITS - 1 - t;
		logic [46:0] dvsr;
		assign dvsr = 47'(dv_s[t].len) << J;

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[t+1].len <= dv_s[t].len;
				dv_s[t+1].sd <= dv_s[t].sd;
				for (int l = 0; l < LANES; l++) begin
					if (dv_s[t].r[l] >= dvsr) begin
						dv_s[t+1].r[l] <= dv_s[t].r[l] - dvsr;
						dv_s[t+1].q[l] <= dv_s[t].q[l] | (DIR_Q_BITS'(1) << J);
					end else begin
						dv_s[t+1].r[l] <= dv_s[t].r[l];
						dv_s[t+1].q[l] <= dv_s[t].q[l];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[t+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[t+1] <= dv_v_s[t];
			end
		end
	end

	// signed direction
	dir_t dir_s;
	logic dir_v_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_s.sd <= dv_s[DIR_Q_BITS].sd;
			for (int l = 0; l < LANES; l++) begin
				if (dv_s[DIR_Q_BITS].sd.zero) begin
					dir_s.d[l] <= '0;
				end else if (dv_s[DIR_Q_BITS].sd.neg[l]) begin
					dir_s.d[l] <= 16'(-{1'b0, dv_s[DIR_Q_BITS].q[l]});
				end else begin
					dir_s.d[l] <= {1'b0, dv_s[DIR_Q_BITS].q[l]};
				end
			end
		end
	end

	// cone falloff
	logic [16:0] cz_cc, cb_cc;
	fall_mode_t mode_d;
	fl_t fl_s [0:FALL_Q_BITS];
	logic fl_v_s [0:FALL_Q_BITS];

	assign cz_cc = {dir_s.d[2][15], dir_s.d[2]} - {cos_cutoff_q[15], cos_cutoff_q};
	assign cb_cc = {cos_beam_q[15], cos_beam_q} - {cos_cutoff_q[15], cos_cutoff_q};

	always_comb begin
		if ($signed(dir_s.d[2]) <= $signed(cos_cutoff_q)) begin
			mode_d = FALL_OFF;
		end else if ($signed(dir_s.d[2]) >= $signed(cos_beam_q)) begin
			mode_d = FALL_FULL;
		end else begin
			mode_d = FALL_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s[0].rem <= {cz_cc[15:0], 14'b0};
			fl_s[0].den <= cb_cc[15:0];
			fl_s[0].q <= '0;
			fl_s[0].mode <= mode_d;
			fl_s[0].dr <= dir_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_v_s <= 1'b0;
			fl_v_s[0] <= 1'b0;
		end else if (adv) begin
			dir_v_s <= dv_v_s[DIR_Q_BITS];
			fl_v_s[0] <= dir_v_s;
		end
	end

	for (genvar t = 0; t < FALL_Q_BITS; t++) begin : g_fall
		localparam int J = FALL_Q_BITS - 1 - t;
		logic [29:0] dvsr;
		assign dvsr = 30'(fl_s[t].den) << J;

		always_ff @(posedge clk) begin
			if (adv) begin
				fl_s[t+1].den <= fl_s[t].den;
				fl_s[t+1].mode <= fl_s[t].mode;
				fl_s[t+1].dr <= fl_s[t].dr;
				if (fl_s[t].rem >= dvsr) begin
					fl_s[t+1].rem <= fl_s[t].rem - dvsr;
					fl_s[t+1].q <= fl_s[t].q | (FALL_Q_BITS'(1) << J);
				end else begin
					fl_s[t+1].rem <= fl_s[t].rem;
					fl_s[t+1].q <= fl_s[t].q;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fl_v_s[t+1] <= 1'b0;
			end else if (adv) begin
				fl_v_s[t+1] <= fl_v_s[t];
			end
		end
	end

	// intensity times falloff
	logic [14:0] f_d;
	logic [LANES-1:0][15:0] inten;
	pr_t pr_s;
	logic pr_v_s;

	assign inten[0] = intensity_r_q;
	assign inten[1] = intensity_g_q;
	assign inten[2] = intensity_b_q;

	always_comb begin
		unique case (fl_s[FALL_Q_BITS].mode)
			FALL_OFF: f_d = '0;
			FALL_FULL: f_d = FALL_ONE;
			FALL_DIV: f_d = {1'b0, fl_s[FALL_Q_BITS].q};
			default: f_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				pr_s.p[l] <= 31'(inten[l]) * 31'(f_d);
			end
			pr_s.dr <= fl_s[FALL_Q_BITS].dr;
		end
	end

	// inverse square divide with saturation
	ch_t ch_s [0:CHAN_Q_BITS];
	logic ch_v_s [0:CHAN_Q_BITS];
	logic [LANES-1:0][56:0] num_d;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			num_d[l] = pr_s.dr.sd.shf ? 57'({pr_s.p[l], 24'b0}) : {pr_s.p[l], 26'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				ch_s[0].sat[l] <= 64'(num_d[l][56:32]) >= pr_s.dr.sd.s;
			end
			ch_s[0].rem <= num_d;
			ch_s[0].q <= '0;
			ch_s[0].dr <= pr_s.dr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_v_s <= 1'b0;
			ch_v_s[0] <= 1'b0;
		end else if (adv) begin
			pr_v_s <= fl_v_s[FALL_Q_BITS];
			ch_v_s[0] <= pr_v_s;
		end
	end

	for (genvar t = 0; t < CHAN_Q_BITS; t++) begin : g_chan
		localparam int J = CHAN_Q_BITS - 1 - t;
		logic [56:0] dvsr;
		assign dvsr = ch_s[t].dr.sd.s[56:0] << J;

		always_ff @(posedge clk) begin
			if (adv) begin
				ch_s[t+1].sat <= ch_s[t].sat;
				ch_s[t+1].dr <= ch_s[t].dr;
				for (int l = 0; l < LANES; l++) begin
					if (64'(ch_s[t].rem[l] >> J) >= ch_s[t].dr.sd.s) begin
						ch_s[t+1].rem[l] <= ch_s[t].rem[l] - dvsr;
						ch_s[t+1].q[l] <= ch_s[t].q[l] | (CHAN_Q_BITS'(1) << J);
					end else begin
						ch_s[t+1].rem[l] <= ch_s[t].rem[l];
						ch_s[t+1].q[l] <= ch_s[t].q[l];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ch_v_s[t+1] <= 1'b0;
			end else if (adv) begin
				ch_v_s[t+1] <= ch_v_s[t];
			end
		end
	end

	// output register
	logic [LANES-1:0][31:0] val_d;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (ch_s[CHAN_Q_BITS].dr.sd.zero) begin
				val_d[l] = '0;
			end else if (ch_s[CHAN_Q_BITS].sat[l]) begin
				val_d[l] = '1;
			end else begin
				val_d[l] = ch_s[CHAN_Q_BITS].q[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dir_x <= ch_s[CHAN_Q_BITS].dr.d[0];
			dir_y <= ch_s[CHAN_Q_BITS].dr.d[1];
			dir_z <= ch_s[CHAN_Q_BITS].dr.d[2];
			value_r <= val_d[0];
			value_g <= val_d[1];
			value_b <= val_d[2];
			zero_distance <= ch_s[CHAN_Q_BITS].dr.sd.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ch_v_s[CHAN_Q_BITS];
		end
	end

`ifndef SYNTHESIS
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_distance |-> value_r == '0 && value_g == '0 && value_b == '0
			&& dir_x == '0 && dir_y == '0 && dir_z == '0)
		else $error("zero distance result not cleared");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> dir_z <= 16'sd16384 && dir_z >= -16'sd16384
			&& dir_x <= 16'sd16384 && dir_x >= -16'sd16384)
		else $error("direction component out of range");

	a_root_norm: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[SQRT_STEPS] && !sq_s[SQRT_STEPS].sd.zero
			|-> sq_s[SQRT_STEPS].root[31] || sq_s[SQRT_STEPS].root[30])
		else $error("length not normalized");

	a_fall_den: assert property (@(posedge clk) disable iff (!arst_n)
		fl_v_s[0] && fl_s[0].mode == FALL_DIV |-> fl_s[0].den != '0)
		else $error("falloff divide by zero");

	a_chan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ch_v_s[CHAN_Q_BITS] && !ch_s[CHAN_Q_BITS].dr.sd.zero && !ch_s[CHAN_Q_BITS].sat[0]
			|-> 64'(ch_s[CHAN_Q_BITS].rem[0]) < ch_s[CHAN_Q_BITS].dr.sd.s)
		else $error("channel remainder not below divisor");
`endif

endmodule

>>> tb/tb_spot_light_attenuation.sv
module tb_spot_light_attenuation;
	timeunit 1ns;
	timeprecision 1ps;

	import spotl_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct {
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		logic zd;
	} light_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic [31:0] value_r;
	logic [31:0] value_g;
	logic [31:0] value_b;
	logic zero_distance;

	spot_light_attenuation dut (.*);

	// shadow copy of the light registers
	logic signed [31:0] lpos_x, lpos_y, lpos_z;
	logic [15:0] inten_r, inten_g, inten_b;
	logic signed [15:0] cutoff_cos, beam_cos;

	point_t pending_points[$];
	light_t expected_light[$];
	int errors;
	int results_seen;
	bit in_xfer, out_xfer;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] unit_part(bit [63:0] n, bit neg, bit [63:0] len);
		bit [63:0] q;
		q = ((n << 14) + (len >> 1)) / len;
		if (q > 16384)
			q = 16384;
		return neg ? 16'(-q) : q[15:0];
	endfunction

	function automatic logic [31:0] arriving(bit [63:0] i, bit [63:0] f, int sh, bit [63:0] s);
		bit [63:0] q;
		q = ((i * f) << sh) / s;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic light_t light_at(point_t p);
		light_t res;
		longint dx, dy, dz, cz;
		bit [63:0] ax, ay, az, m, nx, ny, nz, len, s, f;
		int k, sh;
		dx = longint'(p.x) - longint'(lpos_x);
		dy = longint'(p.y) - longint'(lpos_y);
		dz = longint'(p.z) - longint'(lpos_z);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		m = ax;
		if (ay > m) m = ay;
		if (az > m) m = az;
		res = '{default: '0};
		if (m == 0) begin
			res.zd = 1'b1;
			return res;
		end
		if (m >> 31) begin
			nx = ax >> 1;
			ny = ay >> 1;
			nz = az >> 1;
			sh = 24;
			s = nx * nx + ny * ny + nz * nz;
		end else begin
			k = 0;
			while ((m << k) < (64'd1 << 30))
				k++;
			nx = ax << k;
			ny = ay << k;
			nz = az << k;
			sh = 26;
			s = ax * ax + ay * ay + az * az;
		end
		len = int_sqrt(nx * nx + ny * ny + nz * nz);
		res.dx = unit_part(nx, dx < 0, len);
		res.dy = unit_part(ny, dy < 0, len);
		res.dz = unit_part(nz, dz < 0, len);
		cz = longint'(res.dz);
		if (cz <= longint'(cutoff_cos))
			f = 0;
		else if (cz >= longint'(beam_cos))
			f = 16384;
		else
			f = ((cz - longint'(cutoff_cos)) * 16384)
				/ (longint'(beam_cos) - longint'(cutoff_cos));
		res.r = arriving(64'(inten_r), f, sh, s);
		res.g = arriving(64'(inten_g), f, sh, s);
		res.b = arriving(64'(inten_b), f, sh, s);
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results_seen, field, got,
			want);
		errors++;
	endtask

	// sender: bursts with random gaps
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		point_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			point_x <= '0;
			point_y <= '0;
			point_z <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_light.push_back(light_at('{point_x, point_y, point_z}));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					p = pending_points.pop_front();
					point_x <= p.x;
					point_y <= p.y;
					point_z <= p.z;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern steps through four phases, one long hold-off
	int rx_cycle, hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cycle = 0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			rx_cycle++;
			if (!hold_done && results_seen >= 300) begin
				hold_done = 1;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case ((rx_cycle / 64) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= ((rx_cycle % 8) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		light_t w;
		in_xfer <= in_valid && !in_stall;
		out_xfer <= out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_light.size() == 0) begin
				$display("unexpected transfer out at result %0d", results_seen);
				errors++;
			end else begin
				w = expected_light.pop_front();
				if (dir_x !== w.dx)
					report_mismatch("dir_x", longint'(dir_x), longint'(w.dx));
				if (dir_y !== w.dy)
					report_mismatch("dir_y", longint'(dir_y), longint'(w.dy));
				if (dir_z !== w.dz)
					report_mismatch("dir_z", longint'(dir_z), longint'(w.dz));
				if (value_r !== w.r)
					report_mismatch("value_r", longint'(value_r), longint'(w.r));
				if (value_g !== w.g)
					report_mismatch("value_g", longint'(value_g), longint'(w.g));
				if (value_b !== w.b)
					report_mismatch("value_b", longint'(value_b), longint'(w.b));
				if (zero_distance !== w.zd)
					report_mismatch("zero_distance", longint'(zero_distance),
						longint'(w.zd));
			end
			results_seen++;
		end
	end

	int idle_cycles;
	always @(posedge clk) begin
		if (in_xfer || out_xfer || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_LIGHT_POS_X: lpos_x = v;
			CFG_LIGHT_POS_Y: lpos_y = v;
			CFG_LIGHT_POS_Z: lpos_z = v;
			CFG_INTENSITY_R: inten_r = v[15:0];
			CFG_INTENSITY_G: inten_g = v[15:0];
			CFG_INTENSITY_B: inten_b = v[15:0];
			CFG_COS_CUTOFF: cutoff_cos = v[15:0];
			CFG_COS_BEAM: beam_cos = v[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_light(logic [31:0] x, y, z, logic [15:0] r, g, b, cc, cb);
		cfg_write(CFG_LIGHT_POS_X, x);
		cfg_write(CFG_LIGHT_POS_Y, y);
		cfg_write(CFG_LIGHT_POS_Z, z);
		cfg_write(CFG_INTENSITY_R, {16'd0, r});
		cfg_write(CFG_INTENSITY_G, {16'd0, g});
		cfg_write(CFG_INTENSITY_B, {16'd0, b});
		cfg_write(CFG_COS_CUTOFF, {{16{cc[15]}}, cc});
		cfg_write(CFG_COS_BEAM, {{16{cb[15]}}, cb});
	endtask

	task automatic add_offset(logic [31:0] ox, oy, oz);
		pending_points.push_back('{lpos_x + ox, lpos_y + oy, lpos_z + oz});
	endtask

	function automatic logic [31:0] rand_signed(int bits);
		logic [31:0] v;
		v = $urandom & ((bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1));
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [31:0] corner();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return 32'h1;
		endcase
	endfunction

	task automatic add_random(int n);
		logic [31:0] dz;
		repeat (n) begin
			case ($urandom_range(0, 5))
				0, 1: pending_points.push_back('{$urandom, $urandom, $urandom});
				2: add_offset(rand_signed($urandom_range(0, 18)),
					rand_signed($urandom_range(0, 18)), rand_signed($urandom_range(0, 18)));
				3, 4: begin
					// near the spot axis, either side of the cone edge
					dz = $urandom_range(1, 32'h0100_0000);
					if ($urandom_range(0, 3) == 0)
						dz = -dz;
					add_offset(rand_signed(32) % (dz >> $urandom_range(0, 4) | 1),
						rand_signed(32) % (dz >> $urandom_range(0, 4) | 1), dz);
				end
				default: pending_points.push_back('{corner(), corner(), corner()});
			endcase
		end
	endtask

	task automatic drain();
		while (pending_points.size() > 0 || expected_light.size() > 0 || in_valid)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		results_seen = 0;
		lpos_x = 0;
		lpos_y = 0;
		lpos_z = 0;
		inten_r = INTENSITY_RST;
		inten_g = INTENSITY_RST;
		inten_b = INTENSITY_RST;
		cutoff_cos = COS_CUTOFF_RST;
		beam_cos = COS_BEAM_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, directed points
		add_offset(0, 0, 0);
		add_offset(1, 0, 0);
		add_offset(0, 0, 1);
		add_offset(0, 0, -1);
		add_offset(0, -1, 0);
		add_offset(33 << 16, 0, 100 << 16);
		add_offset(-(30 << 16), 10 << 16, 100 << 16);
		add_offset(0, 36 << 16, 100 << 16);
		pending_points.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		pending_points.push_back('{32'h8000_0000, 0, 0});
		pending_points.push_back('{0, 0, 32'h8000_0000});
		add_random(220);
		drain();

		set_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'd16384, -16'sd16384);
		pending_points.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0001});
		pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		add_random(240);
		drain();

		set_light(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'h8000, 16'd1,
			-16'sd16384, 16'd16384);
		pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		add_offset(0, 0, -5);
		add_random(240);
		drain();

		set_light($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
			16'd0, 16'd16384);
		add_random(240);
		drain();

		set_light(rand_signed(24), rand_signed(24), rand_signed(24), 16'($urandom),
			16'($urandom), 16'($urandom), -16'sd16384, -16'sd16384);
		add_random(120);
		drain();

		set_light(rand_signed(20), rand_signed(20), rand_signed(20), 16'($urandom),
			16'($urandom), 16'($urandom), 16'd12000, 16'd16000);
		add_random(140);
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
